// ===== hw/rtl/lhfm_pkg.sv =====
// ----------------------------------------------------------------------------
// lhfm_pkg: limp-home fault monitor shared definitions
// Command codes, register indexes, reset values and the word structs that
// pass between the monitor's state logic and its top level.
// ----------------------------------------------------------------------------
package lhfm_pkg;

   // time width default and divide-by-ten reciprocal
   localparam int TIME_BITS_DEF = 32;
   localparam int DUR_W         = 29;
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT   = 35;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETARD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FUEL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERTEMP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MAX   = 3'd6;

   // register reset values
   localparam logic [15:0]        RST_COOLDOWN  = 16'd50;
   localparam logic [15:0]        RST_RPM_LIMIT = 16'd3000;
   localparam logic [6:0]         RST_RETARD    = 7'd10;
   localparam logic [7:0]         RST_FUEL      = 8'd110;
   localparam logic signed [8:0]  RST_OVERTEMP  = 9'sd110;
   localparam logic [9:0]         RST_MAP_MIN   = 10'd10;
   localparam logic [9:0]         RST_MAP_MAX   = 10'd400;

   // fixed thresholds and idle outputs
   localparam logic [7:0]  TPS_LOW    = 8'd2;
   localparam logic [7:0]  TPS_HIGH   = 8'd253;
   localparam logic [7:0]  BOOST_BITS = 8'h4F;
   localparam logic [15:0] RPM_NONE   = 16'hFFFF;
   localparam logic [7:0]  FUEL_NONE  = 8'd100;

   // trigger bit positions
   localparam int TRIG_CLT      = 0;
   localparam int TRIG_IAT      = 1;
   localparam int TRIG_MAP      = 2;
   localparam int TRIG_TPS      = 3;
   localparam int TRIG_RAM      = 4;
   localparam int TRIG_OVERTEMP = 6;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_SET    = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_EXIT   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [15:0]       cooldown_tenths;
      logic [15:0]       limp_rpm_limit;
      logic [6:0]        timing_retard;
      logic [7:0]        fuel_correction_limp;
      logic signed [8:0] overtemp_threshold;
      logic [9:0]        map_min_kpa;
      logic [9:0]        map_max_kpa;
   } cfg_type;

   typedef struct packed {
      cmd_type           command;
      logic              clt_fault;
      logic              iat_fault;
      logic              engine_running;
      logic [9:0]        map_kpa;
      logic [7:0]        tps_adc;
      logic signed [8:0] coolant_temp;
      logic              storage_corrupt;
      logic [7:0]        trigger_mask;
   } item_type;

   typedef struct packed {
      logic [7:0]        active_triggers;
      logic              limp_active;
      logic [15:0]       rpm_limit;
      logic signed [7:0] timing_correction;
      logic [7:0]        fuel_correction;
      logic              boost_disable;
      logic [3:0]        reason_code;
   } status_type;

endpackage

// ===== hw/rtl/lhfm_state.sv =====
// ----------------------------------------------------------------------------
// lhfm_state: trigger and latch state with its update logic
// Holds the trigger mask, latch, start and clear times and the last sampled
// mask; evaluates one word and presents the post-update status.
// ----------------------------------------------------------------------------
module lhfm_state #(
   parameter int TIME_BITS = lhfm_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  lhfm_pkg::item_type     item,
   input  logic [TIME_BITS-1:0]   now,
   input  lhfm_pkg::cfg_type      cfg,
   output lhfm_pkg::status_type   status,
   output logic [TIME_BITS-1:0]   elapsed
);

   logic [7:0]           trig_ff, trig_in;
   logic                 latched_ff, latched_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] clear_ff, clear_in;
   logic [7:0]           sampled_ff, sampled_in;

   logic [7:0]           fresh;
   logic [TIME_BITS-1:0] since_clear;
   logic [3:0]           reason;

   // fresh trigger mask from the sample fields
   always_comb begin
      fresh = 8'd0;
      fresh[lhfm_pkg::TRIG_CLT] = item.clt_fault;
      fresh[lhfm_pkg::TRIG_IAT] = item.iat_fault;
      fresh[lhfm_pkg::TRIG_RAM] = item.storage_corrupt;
      if (item.engine_running) begin
         fresh[lhfm_pkg::TRIG_MAP] = (item.map_kpa < cfg.map_min_kpa) ||
                                     (item.map_kpa > cfg.map_max_kpa);
         fresh[lhfm_pkg::TRIG_TPS] = (item.tps_adc < lhfm_pkg::TPS_LOW) ||
                                     (item.tps_adc > lhfm_pkg::TPS_HIGH);
         fresh[lhfm_pkg::TRIG_OVERTEMP] =
            ($signed(item.coolant_temp) > $signed(cfg.overtemp_threshold));
      end
   end

   // state update per command
   always_comb begin
      trig_in     = trig_ff;
      latched_in  = latched_ff;
      start_in    = start_ff;
      clear_in    = clear_ff;
      sampled_in  = sampled_ff;
      since_clear = '0;
      case (item.command)
         lhfm_pkg::CMD_SAMPLE: begin
            if ((sampled_ff & ~fresh) != 8'd0) begin
               clear_in = now;
            end
            sampled_in  = fresh;
            since_clear = now - clear_in;
            if (fresh != 8'd0) begin
               trig_in = fresh;
               if (!latched_ff) begin
                  latched_in = 1'b1;
                  start_in   = now;
               end
            end else if (trig_ff != 8'd0) begin
               if (since_clear >= TIME_BITS'(cfg.cooldown_tenths)) begin
                  trig_in    = 8'd0;
                  latched_in = 1'b0;
                  start_in   = '0;
               end
            end
         end
         lhfm_pkg::CMD_SET: begin
            trig_in = trig_ff | item.trigger_mask;
            if (!latched_ff) begin
               latched_in = 1'b1;
               start_in   = now;
            end
         end
         lhfm_pkg::CMD_CLEAR: begin
            trig_in  = trig_ff & ~item.trigger_mask;
            clear_in = now;
         end
         lhfm_pkg::CMD_EXIT: begin
            trig_in    = 8'd0;
            latched_in = 1'b0;
            start_in   = '0;
         end
         default: begin
            trig_in = trig_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff    <= 8'd0;
         latched_ff <= 1'b0;
         start_ff   <= '0;
         clear_ff   <= '0;
         sampled_ff <= 8'd0;
      end else if (advance) begin
         trig_ff    <= trig_in;
         latched_ff <= latched_in;
         start_ff   <= start_in;
         clear_ff   <= clear_in;
         sampled_ff <= sampled_in;
      end
   end

   // lowest set trigger bit, plus one
   always_comb begin
      reason = 4'd0;
      for (int i = 7; i >= 0; i--) begin
         if (trig_in[i]) begin
            reason = 4'(i + 1);
         end
      end
   end

   // status after the update
   always_comb begin
      status.active_triggers = trig_in;
      status.limp_active     = latched_in;
      status.rpm_limit       = latched_in ? cfg.limp_rpm_limit : lhfm_pkg::RPM_NONE;
      status.timing_correction =
         latched_in ? $signed(8'd0 - {1'b0, cfg.timing_retard}) : 8'sd0;
      status.fuel_correction = latched_in ? cfg.fuel_correction_limp
                                          : lhfm_pkg::FUEL_NONE;
      status.boost_disable   = latched_in && ((trig_in & lhfm_pkg::BOOST_BITS) != 8'd0);
      status.reason_code     = reason;
      elapsed                = latched_in ? (now - start_in) : '0;
   end

endmodule

// ===== hw/rtl/limp_home_fault_monitor_core.sv =====
// Pipeline: input, update and output registers from the req accepting edge to rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; the trigger/latch update is
// combinational, and the limp duration divide-by-ten is one registered 32x32 multiply.
// Reset: synchronous, active high; clears pipeline valids and all monitor state
// and returns every configuration register to its default.
// ----------------------------------------------------------------------------
// limp_home_fault_monitor_core: engine limp-home supervisor
// Samples sensor faults and range checks into a trigger mask, latches limp
// mode with cooldown exit, and reports limits and corrections per word.
// ----------------------------------------------------------------------------
module limp_home_fault_monitor_core #(
   parameter int TIME_BITS = lhfm_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_write,
   input  logic [lhfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lhfm_pkg::CSR_DATA_W-1:0]      csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [31:0]                          req_time_tenths,
   input  logic                                 req_clt_fault,
   input  logic                                 req_iat_fault,
   input  logic                                 req_engine_running,
   input  logic [9:0]                           req_map_kpa,
   input  logic [7:0]                           req_tps_adc,
   input  logic signed [8:0]                    req_coolant_temp,
   input  logic                                 req_storage_corrupt,
   input  logic [7:0]                           req_trigger_mask,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_active_triggers,
   output logic                                 rsp_limp_active,
   output logic [15:0]                          rsp_rpm_limit,
   output logic signed [7:0]                    rsp_timing_correction,
   output logic [7:0]                           rsp_fuel_correction,
   output logic                                 rsp_boost_disable,
   output logic [lhfm_pkg::DUR_W-1:0]           rsp_duration_seconds,
   output logic [3:0]                           rsp_reason_code
);

   localparam int QLO = lhfm_pkg::DIV10_SHIFT;
   localparam int QHI = lhfm_pkg::DIV10_SHIFT + lhfm_pkg::DUR_W - 1;

   lhfm_pkg::cfg_type    cfg_ff;

   logic                 s1_valid_ff, s1_valid_in;
   lhfm_pkg::item_type   s1_item_ff, s1_item_in;
   logic [TIME_BITS-1:0] s1_time_ff;

   logic                 s2_valid_ff, s2_valid_in;
   lhfm_pkg::status_type s2_status_ff;
   logic [TIME_BITS-1:0] s2_elapsed_ff;

   logic                 s3_valid_ff, s3_valid_in;
   lhfm_pkg::status_type s3_status_ff;
   logic [lhfm_pkg::DUR_W-1:0] s3_dur_ff;

   logic                 s1_ready, s2_ready, s3_ready;
   logic                 advance;
   lhfm_pkg::status_type upd_status;
   logic [TIME_BITS-1:0] upd_elapsed;
   logic [63:0]          dur_product;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_tenths      <= lhfm_pkg::RST_COOLDOWN;
         cfg_ff.limp_rpm_limit       <= lhfm_pkg::RST_RPM_LIMIT;
         cfg_ff.timing_retard        <= lhfm_pkg::RST_RETARD;
         cfg_ff.fuel_correction_limp <= lhfm_pkg::RST_FUEL;
         cfg_ff.overtemp_threshold   <= lhfm_pkg::RST_OVERTEMP;
         cfg_ff.map_min_kpa          <= lhfm_pkg::RST_MAP_MIN;
         cfg_ff.map_max_kpa          <= lhfm_pkg::RST_MAP_MAX;
      end else if (csr_write) begin
         case (csr_index)
            lhfm_pkg::CSR_COOLDOWN:  cfg_ff.cooldown_tenths      <= csr_wdata;
            lhfm_pkg::CSR_RPM_LIMIT: cfg_ff.limp_rpm_limit       <= csr_wdata;
            lhfm_pkg::CSR_RETARD:    cfg_ff.timing_retard        <= csr_wdata[6:0];
            lhfm_pkg::CSR_FUEL:      cfg_ff.fuel_correction_limp <= csr_wdata[7:0];
            lhfm_pkg::CSR_OVERTEMP:  cfg_ff.overtemp_threshold   <= $signed(csr_wdata[8:0]);
            lhfm_pkg::CSR_MAP_MIN:   cfg_ff.map_min_kpa          <= csr_wdata[9:0];
            lhfm_pkg::CSR_MAP_MAX:   cfg_ff.map_max_kpa          <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control, a stage moves when the next one has room
   assign s3_ready = !s3_valid_ff || !rsp_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign advance  = s1_valid_ff && s2_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // input word register
   always_comb begin
      s1_item_in.command         = lhfm_pkg::cmd_type'(req_command);
      s1_item_in.clt_fault       = req_clt_fault;
      s1_item_in.iat_fault       = req_iat_fault;
      s1_item_in.engine_running  = req_engine_running;
      s1_item_in.map_kpa         = req_map_kpa;
      s1_item_in.tps_adc         = req_tps_adc;
      s1_item_in.coolant_temp    = req_coolant_temp;
      s1_item_in.storage_corrupt = req_storage_corrupt;
      s1_item_in.trigger_mask    = req_trigger_mask;
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_item_ff <= s1_item_in;
         s1_time_ff <= req_time_tenths[TIME_BITS-1:0];
      end
   end

   // trigger and latch update
   lhfm_state #(
      .TIME_BITS (TIME_BITS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .now     (s1_time_ff),
      .cfg     (cfg_ff),
      .status  (upd_status),
      .elapsed (upd_elapsed)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_status_ff  <= upd_status;
         s2_elapsed_ff <= upd_elapsed;
      end
   end

   // elapsed tenths to seconds: multiply by reciprocal of ten, keep upper bits
   assign dur_product = 64'(32'(s2_elapsed_ff)) * 64'(lhfm_pkg::DIV10_RECIP);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_status_ff <= s2_status_ff;
         s3_dur_ff    <= dur_product[QHI:QLO];
      end
   end

   // result word
   assign rsp_valid             = s3_valid_ff;
   assign rsp_active_triggers   = s3_status_ff.active_triggers;
   assign rsp_limp_active       = s3_status_ff.limp_active;
   assign rsp_rpm_limit         = s3_status_ff.rpm_limit;
   assign rsp_timing_correction = s3_status_ff.timing_correction;
   assign rsp_fuel_correction   = s3_status_ff.fuel_correction;
   assign rsp_boost_disable     = s3_status_ff.boost_disable;
   assign rsp_duration_seconds  = s3_dur_ff;
   assign rsp_reason_code       = s3_status_ff.reason_code;

endmodule
